// ===== design/fvmm_pkg.sv =====
// Shared types, codes, constants and helpers for the fp32 vector-matrix multiplier.
package fvmm_pkg;

    localparam int WIN_W = 102;
    localparam int CFG_W = 11;
    localparam int IDX_W = 10;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
    localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;

    typedef enum logic {
        OP_WEIGHT = 1'b0,
        OP_MATRIX = 1'b1
    } t_op;

    typedef enum logic {
        CFG_ROWS    = 1'b0,
        CFG_COLUMNS = 1'b1
    } t_cfg_idx;

    function automatic logic [WIN_W-1:0] shr_jam(input logic [WIN_W-1:0] v,
                                                 input logic [8:0] s);
        logic [WIN_W-1:0] lost;
        lost = v & ~({WIN_W{1'b1}} << s);
        return (v >> s) | {{(WIN_W-1){1'b0}}, |lost};
    endfunction

endpackage

// ===== design/fvmm_fma.sv =====
// Six-stage binary32 fused multiply-add with a single round to nearest even.
module fvmm_fma import fvmm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    input  logic [31:0] i_z,
    output logic [31:0] o_res
);

    // stage A: unpack, special operands, multiply
    logic        sx, sy, sz, sp;
    logic [7:0]  ex, ey, ez, exe, eye, eze;
    logic [22:0] fx, fy, fz;
    logic        xz, yz, zz, xnan, ynan, znan, xinf, yinf, zinf;
    logic        a_spec;
    logic [31:0] a_sbits;
    logic [47:0] a_prod;
    logic signed [10:0] a_q;
    logic [8:0]  a_exy;

    always_comb begin
        sx = i_x[31];
        sy = i_y[31];
        sz = i_z[31];
        sp = sx ^ sy;
        ex = i_x[30:23];
        ey = i_y[30:23];
        ez = i_z[30:23];
        fx = i_x[22:0];
        fy = i_y[22:0];
        fz = i_z[22:0];
        xz = (i_x[30:0] == 31'd0);
        yz = (i_y[30:0] == 31'd0);
        zz = (i_z[30:0] == 31'd0);
        xnan = (ex == 8'hFF) && (fx != 23'd0);
        ynan = (ey == 8'hFF) && (fy != 23'd0);
        znan = (ez == 8'hFF) && (fz != 23'd0);
        xinf = (ex == 8'hFF);
        yinf = (ey == 8'hFF);
        zinf = (ez == 8'hFF);
        a_spec  = 1'b1;
        a_sbits = QNAN_BITS;
        if (xnan || ynan || znan) begin
            a_sbits = QNAN_BITS;
        end else if (xinf || yinf) begin
            if (xz || yz) begin
                a_sbits = QNAN_BITS;
            end else if (zinf && (sz != sp)) begin
                a_sbits = QNAN_BITS;
            end else begin
                a_sbits = {sp, INF_BITS[30:0]};
            end
        end else if (zinf) begin
            a_sbits = i_z;
        end else if (xz || yz) begin
            a_sbits = zz ? {sp & sz, 31'd0} : i_z;
        end else begin
            a_spec = 1'b0;
        end
        exe = (ex == 8'd0) ? 8'd1 : ex;
        eye = (ey == 8'd0) ? 8'd1 : ey;
        eze = (ez == 8'd0) ? 8'd1 : ez;
        a_prod = {ex != 8'd0, fx} * {ey != 8'd0, fy};
        a_q = $signed({3'b000, eze}) - $signed({3'b000, exe}) - $signed({3'b000, eye})
            + 11'sd176;
        a_exy = {1'b0, exe} + {1'b0, eye};
    end

    logic               r_a_spec, r_a_sp, r_a_sz, r_a_zz;
    logic [31:0]        r_a_sbits;
    logic [47:0]        r_a_prod;
    logic [23:0]        r_a_mz;
    logic signed [10:0] r_a_q;
    logic [8:0]         r_a_exy;
    logic [7:0]         r_a_ez;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_spec  <= a_spec;
            r_a_sbits <= a_sbits;
            r_a_sp    <= sp;
            r_a_sz    <= sz;
            r_a_zz    <= zz;
            r_a_prod  <= a_prod;
            r_a_mz    <= {ez != 8'd0, fz};
            r_a_q     <= a_q;
            r_a_exy   <= a_exy;
            r_a_ez    <= eze;
        end
    end

    // stage B: align addend and product in one window
    logic [WIN_W-1:0]   pw, mzw, b_a, b_p;
    logic signed [10:0] b_shc, b_nq;
    logic signed [9:0]  b_elsb;

    always_comb begin
        pw    = {28'd0, r_a_prod, 26'd0};
        mzw   = {78'd0, r_a_mz};
        b_shc = r_a_q - 11'sd77;
        b_nq  = -r_a_q;
        if ((r_a_q > 11'sd77) && !r_a_zz) begin
            b_a    = mzw << 77;
            b_p    = shr_jam(pw, b_shc[8:0]);
            b_elsb = $signed({2'b00, r_a_ez}) - 10'sd227;
        end else if (r_a_q >= 11'sd0) begin
            b_a    = mzw << r_a_q[6:0];
            b_p    = pw;
            b_elsb = $signed({1'b0, r_a_exy}) - 10'sd326;
        end else begin
            b_a    = shr_jam(mzw, b_nq[8:0]);
            b_p    = pw;
            b_elsb = $signed({1'b0, r_a_exy}) - 10'sd326;
        end
    end

    logic              r_b_spec, r_b_sp, r_b_sz;
    logic [31:0]       r_b_sbits;
    logic [WIN_W-1:0]  r_b_a, r_b_p;
    logic signed [9:0] r_b_elsb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_spec  <= r_a_spec;
            r_b_sbits <= r_a_sbits;
            r_b_sp    <= r_a_sp;
            r_b_sz    <= r_a_sz;
            r_b_a     <= b_a;
            r_b_p     <= b_p;
            r_b_elsb  <= b_elsb;
        end
    end

    // stage C: signed magnitude add
    logic [WIN_W:0]   c_d;
    logic [WIN_W-1:0] c_m;
    logic             c_s;

    always_comb begin
        c_d = {1'b0, r_b_p} - {1'b0, r_b_a};
        if (r_b_sp == r_b_sz) begin
            c_m = r_b_p + r_b_a;
            c_s = r_b_sp;
        end else if (!c_d[WIN_W]) begin
            c_m = c_d[WIN_W-1:0];
            c_s = r_b_sp;
        end else begin
            c_m = r_b_a - r_b_p;
            c_s = r_b_sz;
        end
    end

    logic              r_c_spec, r_c_s;
    logic [31:0]       r_c_sbits;
    logic [WIN_W-1:0]  r_c_m;
    logic signed [9:0] r_c_elsb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_spec  <= r_b_spec;
            r_c_sbits <= r_b_sbits;
            r_c_s     <= c_s;
            r_c_m     <= c_m;
            r_c_elsb  <= r_b_elsb;
        end
    end

    // stage D: leading one
    logic [6:0] d_l;

    always_comb begin
        d_l = 7'd0;
        for (int i = 0; i < WIN_W; i++) begin
            if (r_c_m[i]) begin
                d_l = 7'(i);
            end
        end
    end

    logic              r_d_spec, r_d_s, r_d_zero;
    logic [31:0]       r_d_sbits;
    logic [WIN_W-1:0]  r_d_m;
    logic [6:0]        r_d_l;
    logic signed [9:0] r_d_elsb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_spec  <= r_c_spec;
            r_d_sbits <= r_c_sbits;
            r_d_s     <= r_c_s;
            r_d_zero  <= (r_c_m == '0);
            r_d_m     <= r_c_m;
            r_d_l     <= d_l;
            r_d_elsb  <= r_c_elsb;
        end
    end

    // stage E: normalize, exponent, subnormal shift
    logic [WIN_W-1:0]   e_t;
    logic signed [10:0] e_be, e_nb;
    logic [7:0]         e_extra;

    always_comb begin
        e_t  = r_d_m << (7'(WIN_W - 1) - r_d_l);
        e_be = $signed({4'b0000, r_d_l}) + $signed({r_d_elsb[9], r_d_elsb}) + 11'sd127;
        e_nb = 11'sd1 - e_be;
        e_extra = (e_be < 11'sd1) ? e_nb[7:0] : 8'd0;
    end

    logic               r_e_spec, r_e_s, r_e_zero;
    logic [31:0]        r_e_sbits;
    logic [WIN_W-1:0]   r_e_t;
    logic signed [10:0] r_e_be;
    logic [7:0]         r_e_extra;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_spec  <= r_d_spec;
            r_e_sbits <= r_d_sbits;
            r_e_s     <= r_d_s;
            r_e_zero  <= r_d_zero;
            r_e_t     <= e_t;
            r_e_be    <= e_be;
            r_e_extra <= e_extra;
        end
    end

    // stage F: round and pack
    logic [WIN_W-1:0]   f_x;
    logic               f_inc;
    logic [24:0]        f_sig;
    logic signed [10:0] f_bm1;
    logic [32:0]        f_bits;
    logic [31:0]        f_res;

    always_comb begin
        f_x   = shr_jam(r_e_t, 9'd76 + {1'b0, r_e_extra});
        f_inc = f_x[1] & (f_x[0] | f_x[2]);
        f_sig = {1'b0, f_x[25:2]} + {24'd0, f_inc};
        f_bm1 = r_e_be - 11'sd1;
        if (r_e_be >= 11'sd1) begin
            f_bits = {f_bm1[9:0], 23'd0} + {8'd0, f_sig};
        end else begin
            f_bits = {8'd0, f_sig};
        end
        if (f_bits >= {1'b0, INF_BITS}) begin
            f_bits = {1'b0, INF_BITS};
        end
        if (r_e_spec) begin
            f_res = r_e_sbits;
        end else if (r_e_zero) begin
            f_res = 32'd0;
        end else begin
            f_res = {r_e_s, f_bits[30:0]};
        end
    end

    logic [31:0] r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= f_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== design/fp32_vector_matrix_multiply.sv =====
// Top level: weight and accumulator memories, row/column sequencing, FMA pipe, output register.
//
//  channel | dir | handshake                  | payload
//  cfg     | in  | i_cfg_we                   | i_cfg_index, i_cfg_data
//  in      | in  | i_in_valid / o_in_ready    | i_operation, i_weight_index, i_value_bits
//  out     | out | o_out_valid / i_out_ready  | o_result_bits, o_result_column, o_final_column
//
// One beat per cycle while o_in_ready is high; a result goes through read, 6 FMA stages and out.
// Below row 0 with fewer than 8 columns, a beat waits until the pending accumulator write
// for its column leaves the 7-deep read-to-write path of the accumulator memory.
// Reset is synchronous; memories need no clearing, so beats are taken right after reset.
// The pipe halts only when a result meets a full, stalled output register.
module fp32_vector_matrix_multiply import fvmm_pkg::*; #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_operation,
    input  logic [IDX_W-1:0] i_weight_index,
    input  logic [31:0]      i_value_bits,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [31:0]      o_result_bits,
    output logic [IDX_W-1:0] o_result_column,
    output logic             o_final_column
);

    localparam int RPW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CPW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int WXW    = (RPW > IDX_W) ? RPW : IDX_W;
    localparam int CXW    = (CPW > IDX_W) ? CPW : IDX_W;
    localparam int STAGES = 7;

    typedef struct packed {
        logic           valid;
        logic           first;
        logic           emit;
        logic           last;
        logic [CPW-1:0] col;
    } t_ctl;

    logic [CFG_W-1:0] r_rows, r_cols;
    logic [RPW-1:0]   r_row_pos, n_row_pos, cur_r, nrm1;
    logic [CPW-1:0]   r_col_pos, n_col_pos, cur_p, ncm1;
    logic [16:0]      nr_full, nc_full, nrm1_full, ncm1_full;
    logic             en, hazard, acc_in, acc_matrix, acc_weight, w_in_range;
    logic [WXW-1:0]   wext;
    logic [CXW-1:0]   cext;
    t_ctl             r_ctl [1:STAGES];
    t_ctl             s0_ctl;
    logic [31:0]      r_wmem [MAX_ROWS];
    logic [31:0]      r_amem [MAX_COLUMNS];
    logic [31:0]      r_w_rd, r_acc_rd, r_y, fma_z, fma_res;
    logic             r_out_valid;
    logic [31:0]      r_out_bits;
    logic [IDX_W-1:0] r_out_col;
    logic             r_out_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(1);
            r_cols <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROWS:    r_rows <= i_cfg_data;
                CFG_COLUMNS: r_cols <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        if (r_rows == '0) begin
            nr_full = 17'd1;
        end else if ({6'd0, r_rows} > 17'(MAX_ROWS)) begin
            nr_full = 17'(MAX_ROWS);
        end else begin
            nr_full = {6'd0, r_rows};
        end
        if (r_cols == '0) begin
            nc_full = 17'd1;
        end else if ({6'd0, r_cols} > 17'(MAX_COLUMNS)) begin
            nc_full = 17'(MAX_COLUMNS);
        end else begin
            nc_full = {6'd0, r_cols};
        end
        nrm1_full = nr_full - 17'd1;
        ncm1_full = nc_full - 17'd1;
        nrm1 = nrm1_full[RPW-1:0];
        ncm1 = ncm1_full[CPW-1:0];
    end

    always_comb begin
        if ((r_row_pos > nrm1) || (r_col_pos > ncm1)) begin
            cur_r = '0;
            cur_p = '0;
        end else begin
            cur_r = r_row_pos;
            cur_p = r_col_pos;
        end
    end

    always_comb begin
        hazard = 1'b0;
        for (int i = 1; i <= STAGES; i++) begin
            if (r_ctl[i].valid && (r_ctl[i].col == cur_p) && (cur_r != '0)) begin
                hazard = 1'b1;
            end
        end
    end

    assign en         = !(r_ctl[STAGES].valid && r_ctl[STAGES].emit && r_out_valid
                          && !i_out_ready);
    assign o_in_ready = en && !hazard;
    assign acc_in     = i_in_valid && o_in_ready;
    assign acc_matrix = acc_in && (i_operation == OP_MATRIX);
    assign acc_weight = acc_in && (i_operation == OP_WEIGHT);
    assign wext       = WXW'(i_weight_index);
    assign w_in_range = ({22'd0, i_weight_index} < 32'(MAX_ROWS));

    always_comb begin
        n_row_pos = r_row_pos;
        n_col_pos = r_col_pos;
        if (acc_matrix) begin
            if (cur_p == ncm1) begin
                n_col_pos = '0;
                n_row_pos = (cur_r == nrm1) ? '0 : RPW'(cur_r + 1'b1);
            end else begin
                n_row_pos = cur_r;
                n_col_pos = CPW'(cur_p + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else begin
            r_row_pos <= n_row_pos;
            r_col_pos <= n_col_pos;
        end
    end

    always_comb begin
        s0_ctl.valid = acc_matrix;
        s0_ctl.first = (cur_r == '0);
        s0_ctl.emit  = (cur_r == nrm1);
        s0_ctl.last  = (cur_p == ncm1);
        s0_ctl.col   = cur_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= STAGES; i++) begin
                r_ctl[i] <= '0;
            end
        end else if (en) begin
            r_ctl[1] <= s0_ctl;
            for (int i = 2; i <= STAGES; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_weight && w_in_range) begin
            r_wmem[wext[RPW-1:0]] <= i_value_bits;
        end
        if (en) begin
            r_w_rd <= r_wmem[cur_r];
            r_y    <= i_value_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_ctl[STAGES].valid) begin
            r_amem[r_ctl[STAGES].col] <= fma_res;
        end
        if (en) begin
            r_acc_rd <= r_amem[cur_p];
        end
    end

    assign fma_z = r_ctl[1].first ? NEG_ZERO : r_acc_rd;

    fvmm_fma u_fma (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_w_rd),
        .i_y   (r_y),
        .i_z   (fma_z),
        .o_res (fma_res)
    );

    assign cext = CXW'(r_ctl[STAGES].col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && r_ctl[STAGES].valid && r_ctl[STAGES].emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_ctl[STAGES].valid && r_ctl[STAGES].emit) begin
            r_out_bits  <= fma_res;
            r_out_col   <= cext[IDX_W-1:0];
            r_out_final <= r_ctl[STAGES].last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_bits   = r_out_bits;
    assign o_result_column = r_out_col;
    assign o_final_column  = r_out_final;

endmodule

// ===== design/fvmm_checker.sv =====
// Port-level assertions for the fp32 vector-matrix multiplier, bound to the top level.
module fvmm_checker import fvmm_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [31:0]      o_result_bits,
    input logic [IDX_W-1:0] o_result_column,
    input logic             o_final_column
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result_bits) && $stable(o_result_column)
            && $stable(o_final_column))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    a_canon_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_bits[30:23] == 8'hFF) && (o_result_bits[22:0] != 23'd0)
            |-> o_result_bits == QNAN_BITS)
        else $error("non-canonical NaN result");

endmodule

bind fp32_vector_matrix_multiply fvmm_checker u_fvmm_checker (.*);

// ===== verif/fp32_vector_matrix_multiply_tb.sv =====
// Testbench for the fp32 vector-matrix multiplier: directed cases, random matrices, checked results.
`timescale 1ns / 1ps

module fp32_vector_matrix_multiply_tb import fvmm_pkg::*;;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLUMNS = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN       = 20;

    typedef struct {
        logic [31:0]      bits;
        logic [IDX_W-1:0] column;
        logic             last;
    } t_result;

    class gemv_scoreboard;
        logic [31:0] weights [MAX_ROWS];
        logic [31:0] accs [MAX_COLUMNS];
        int unsigned row_pos, col_pos, rows_reg, cols_reg;
        t_result pending[$];
        int errors;

        function new();
            row_pos = 0;
            col_pos = 0;
            rows_reg = 1;
            cols_reg = 1;
            errors = 0;
        endfunction

        static function logic [63:0] jam_right(logic [63:0] m, int d);
            logic [63:0] mask;
            if (d <= 0) return m;
            if (d >= 64) return {63'd0, m != 0};
            mask = (64'd1 << d) - 64'd1;
            return (m >> d) | {63'd0, (m & mask) != 0};
        endfunction

        static function logic [31:0] round_pack(logic s, logic [63:0] m, int e);
            int ex, sh;
            logic [63:0] sig, rem, half, packed_bits;
            while (!m[63]) begin
                m = m << 1;
                e--;
            end
            ex = e + 190;
            sh = ex >= 1 ? 40 : 41 - ex;
            if (sh > 64) begin
                sig = 0;
            end else if (sh == 64) begin
                sig = (m > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
            end else begin
                rem = m & ((64'd1 << sh) - 64'd1);
                half = 64'd1 << (sh - 1);
                sig = m >> sh;
                if (rem > half || (rem == half && sig[0])) sig++;
            end
            packed_bits = ex >= 1 ? (64'(ex - 1) << 23) + sig : sig;
            if (packed_bits >= 64'h7F80_0000) packed_bits = 64'h7F80_0000;
            return {s, packed_bits[30:0]};
        endfunction

        static function logic [31:0] fused_mac(logic [31:0] x, logic [31:0] y, logic [31:0] z);
            logic sp, sb, ss, s;
            logic [7:0] ex, ey, ez;
            logic [22:0] fx, fy, fz;
            logic xz, yz, zz;
            logic [63:0] mp, mc, mb, ms, m;
            int ep, ec, eb, es;
            sp = x[31] ^ y[31];
            ex = x[30:23]; ey = y[30:23]; ez = z[30:23];
            fx = x[22:0]; fy = y[22:0]; fz = z[22:0];
            xz = x[30:0] == 0; yz = y[30:0] == 0; zz = z[30:0] == 0;
            if ((ex == 8'hFF && fx != 0) || (ey == 8'hFF && fy != 0) || (ez == 8'hFF && fz != 0))
                return QNAN_BITS;
            if (ex == 8'hFF || ey == 8'hFF) begin
                if (xz || yz) return QNAN_BITS;
                if (ez == 8'hFF && z[31] != sp) return QNAN_BITS;
                return {sp, INF_BITS[30:0]};
            end
            if (ez == 8'hFF) return z;
            if (xz || yz) begin
                if (zz) return {sp & z[31], 31'd0};
                return z;
            end
            mp = 64'({ex != 0, fx}) * 64'({ey != 0, fy});
            ep = (ex != 0 ? int'(ex) - 150 : -149) + (ey != 0 ? int'(ey) - 150 : -149);
            while (!mp[62]) begin
                mp = mp << 1;
                ep--;
            end
            if (zz) return round_pack(sp, mp, ep);
            mc = 64'({ez != 0, fz});
            ec = ez != 0 ? int'(ez) - 150 : -149;
            while (!mc[62]) begin
                mc = mc << 1;
                ec--;
            end
            if (ep >= ec) begin
                mb = mp; eb = ep; sb = sp; ms = mc; es = ec; ss = z[31];
            end else begin
                mb = mc; eb = ec; sb = z[31]; ms = mp; es = ep; ss = sp;
            end
            ms = jam_right(ms, eb - es);
            if (sb == ss) begin
                m = mb + ms; s = sb;
            end else if (mb >= ms) begin
                m = mb - ms; s = sb;
            end else begin
                m = ms - mb; s = ss;
            end
            if (m == 0) return 32'd0;
            return round_pack(s, m, eb);
        endfunction

        static function int unsigned clamp_count(int unsigned v, int unsigned lim);
            if (v == 0) return 1;
            return v > lim ? lim : v;
        endfunction

        function void configure(t_cfg_idx idx, logic [CFG_W-1:0] value);
            if (idx == CFG_ROWS) rows_reg = value;
            else cols_reg = value;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void note_input(t_op op, logic [IDX_W-1:0] widx, logic [31:0] value);
            int unsigned nr, nc;
            logic [31:0] acc;
            t_result res;
            if (op == OP_WEIGHT) begin
                weights[widx] = value;
                return;
            end
            nr = clamp_count(rows_reg, MAX_ROWS);
            nc = clamp_count(cols_reg, MAX_COLUMNS);
            if (row_pos >= nr || col_pos >= nc) begin
                row_pos = 0;
                col_pos = 0;
            end
            acc = fused_mac(weights[row_pos], value, row_pos == 0 ? NEG_ZERO : accs[col_pos]);
            accs[col_pos] = acc;
            if (row_pos == nr - 1) begin
                res.bits = acc;
                res.column = IDX_W'(col_pos);
                res.last = col_pos == nc - 1;
                pending.push_back(res);
            end
            if (col_pos + 1 >= nc) begin
                col_pos = 0;
                row_pos = row_pos + 1 >= nr ? 0 : row_pos + 1;
            end else begin
                col_pos++;
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [31:0] bits, logic [IDX_W-1:0] column, logic last);
            t_result want;
            if (pending.size() == 0) begin
                report("unexpected result", bits, 32'd0);
                return;
            end
            want = pending.pop_front();
            if (bits !== want.bits) report("result_bits", bits, want.bits);
            if (column !== want.column) report("result_column", 32'(column), 32'(want.column));
            if (last !== want.last) report("final_column", 32'(last), 32'(want.last));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [0:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_operation;
    logic [IDX_W-1:0] i_weight_index;
    logic [31:0]      i_value_bits;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [31:0]      o_result_bits;
    logic [IDX_W-1:0] o_result_column;
    logic             o_final_column;

    gemv_scoreboard sb;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold;
    int cycles;
    bit loaded [MAX_ROWS];
    int random_items;

    fp32_vector_matrix_multiply #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLUMNS(MAX_COLUMNS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_weight_index (i_weight_index),
        .i_value_bits   (i_value_bits),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_bits  (o_result_bits),
        .o_result_column(o_result_column),
        .o_final_column (o_final_column)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // hold off on request, else stall at random
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_ready = 1'b0;
            rx_hold--;
        end else begin
            i_out_ready = $urandom_range(99) >= rx_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_result_bits, o_result_column, o_final_column);
    end

    function automatic logic [31:0] pick_float();
        logic s;
        s = 1'($urandom);
        case ($urandom_range(19))
            0: return {s, 31'd0};
            1: return {s, 8'hFF, 23'd0};
            2: return {s, 8'hFF, 23'($urandom) | 23'd1};
            3: return {s, 8'h00, 23'($urandom)};
            4: return {s, 8'($urandom_range(250, 254)), 23'($urandom)};
            5: return $urandom;
            default: return {s, 8'($urandom_range(110, 144)), 23'($urandom)};
        endcase
    endfunction

    task automatic send(t_op op, logic [IDX_W-1:0] widx, logic [31:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_operation = op;
        i_weight_index = widx;
        i_value_bits = value;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(op, widx, value);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.configure(idx, value);
    endtask

    task automatic load_weight(int idx, logic [31:0] value);
        send(OP_WEIGHT, IDX_W'(idx), value);
        loaded[idx] = 1'b1;
    endtask

    // set shape, make sure every used weight is loaded, then stream whole matrices
    task automatic run_shape(int r_cfg, int c_cfg, int sets, bit count_random);
        int nr, nc;
        write_reg(CFG_ROWS, CFG_W'(r_cfg));
        write_reg(CFG_COLUMNS, CFG_W'(c_cfg));
        nr = gemv_scoreboard::clamp_count(r_cfg, MAX_ROWS);
        nc = gemv_scoreboard::clamp_count(c_cfg, MAX_COLUMNS);
        for (int i = 0; i < nr; i++)
            if (!loaded[i] || $urandom_range(3) == 0) load_weight(i, pick_float());
        for (int k = 0; k < sets * nr * nc; k++) begin
            if ($urandom_range(19) == 0) begin
                load_weight($urandom_range(MAX_ROWS - 1), pick_float());
                if (count_random) random_items++;
            end
            send(OP_MATRIX, IDX_W'($urandom), pick_float());
            if (count_random) random_items++;
        end
    endtask

    initial begin
        int mode;
        int idle_tx [4] = '{0, 64, 0, 23};
        int idle_rx [4] = '{0, 0, 64, 23};
        sb = new();
        rx_hold = 0;
        random_items = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_operation = 1'b0;
        i_weight_index = '0;
        i_value_bits = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // single product: inf*0, NaN, overflow, underflow tie, signed zero
        write_reg(CFG_ROWS, CFG_W'(1));
        write_reg(CFG_COLUMNS, CFG_W'(1));
        load_weight(1023, 32'hFFFF_FFFF);
        load_weight(0, INF_BITS);
        send(OP_MATRIX, '1, 32'h0000_0000);
        send(OP_MATRIX, '0, 32'hBF80_0000);
        load_weight(0, 32'h7F7F_FFFF);
        send(OP_MATRIX, '0, 32'h7F7F_FFFF);
        send(OP_MATRIX, '0, 32'hFF80_0001);
        load_weight(0, 32'h0000_0001);
        send(OP_MATRIX, '0, 32'h3F00_0000);
        send(OP_MATRIX, '0, 32'h3FC0_0000);
        load_weight(0, NEG_ZERO);
        send(OP_MATRIX, '0, 32'h0000_0000);
        send(OP_MATRIX, '0, 32'h807F_FFFF);
        // two rows: inf-inf, cancellation to zero, plain accumulation
        write_reg(CFG_ROWS, CFG_W'(2));
        write_reg(CFG_COLUMNS, CFG_W'(3));
        load_weight(0, 32'h3F80_0000);
        load_weight(1, 32'hBF80_0000);
        send(OP_MATRIX, '0, INF_BITS);
        send(OP_MATRIX, '0, 32'h4000_0000);
        send(OP_MATRIX, '0, 32'h0080_0000);
        send(OP_MATRIX, '0, INF_BITS);
        send(OP_MATRIX, '0, 32'h4000_0000);
        send(OP_MATRIX, '0, 32'h4040_0000);

        // zero counts run as one
        run_shape(0, 5, 1, 1'b0);
        run_shape(4, 0, 1, 1'b0);

        // fill the block while the receiver holds off
        wait_idle();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold = 400;
        run_shape(1, 4, 30, 1'b0);

        mode = 0;
        while (random_items < 640) begin
            tx_idle_pct = idle_tx[mode % 4];
            rx_stall_pct = idle_rx[mode % 4];
            run_shape($urandom_range(1, 6), $urandom_range(1, 12), $urandom_range(1, 3), 1'b1);
            if ($urandom_range(3) == 0) mode++;
        end

        wait_idle();
        repeat (DRAIN) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
